@@ rtl/core/mppw_pkg.sv @@
// shared types and constants of the magnitude peak-to-peak window block
`default_nettype none
package mppw_pkg;

    localparam int AXIS_W     = 16;
    localparam int SUM_W      = 32;
    localparam int WL_W       = 13;
    localparam int CNT_W      = 12;
    localparam int P2P_W      = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [WL_W-1:0] WL_RESET   = 13'd200;
    localparam logic [WL_W-1:0] MAX_WINDOW = 13'd4096;

    // one classified request handed from front to back
    typedef struct packed {
        logic             active;
        logic [SUM_W-1:0] sum;
    } t_job;

    // handshake between a producer and the queue, or the queue and a consumer
    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_req;

endpackage
`default_nettype wire

@@ rtl/core/mppw_if.sv @@
// channel interfaces for sample requests and peak-to-peak results
`default_nettype none
interface mppw_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 active;
    logic signed [mppw_pkg::AXIS_W-1:0]   axis_x;
    logic signed [mppw_pkg::AXIS_W-1:0]   axis_y;

    modport source (output valid, output active, output axis_x, output axis_y, input ready);
    modport sink   (input valid, input active, input axis_x, input axis_y, output ready);
endinterface

interface mppw_out_if;
    logic                          valid;
    logic                          ready;
    logic [mppw_pkg::P2P_W-1:0]    peak_to_peak;

    modport source (output valid, output peak_to_peak, input ready);
    modport sink   (input valid, input peak_to_peak, output ready);
endinterface
`default_nettype wire

@@ rtl/core/mppw_front.sv @@
// front end: accepts sample requests and forms the sum of squares
`default_nettype none
module mppw_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    mppw_in_if.sink              i_in,
    input  wire                  i_push_ready,
    output mppw_pkg::t_job_req   o_push
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_SQX  = 3'b010,
        F_SQY  = 3'b100
    } t_fstate;

    t_fstate r_state, n_state;

    logic [mppw_pkg::AXIS_W-1:0] r_ax, r_ay;
    logic                        r_active;
    logic [mppw_pkg::SUM_W-1:0]  r_sum;
    logic [mppw_pkg::AXIS_W-1:0] mul_op;
    logic [mppw_pkg::SUM_W-1:0]  product;
    logic                        accept;

    function automatic logic [mppw_pkg::AXIS_W-1:0] abs16(
        input logic [mppw_pkg::AXIS_W-1:0] v
    );
        // most negative value maps onto itself, read as unsigned
        return v[mppw_pkg::AXIS_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign i_in.ready = (r_state == F_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // one shared multiplier, x first then y
    assign mul_op  = (r_state == F_SQX) ? r_ax : r_ay;
    assign product = mppw_pkg::SUM_W'(mul_op) * mppw_pkg::SUM_W'(mul_op);

    assign o_push.valid      = (r_state == F_SQY);
    assign o_push.job.active = r_active;
    assign o_push.job.sum    = r_sum + product;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept) n_state = F_SQX;
            end
            F_SQX: n_state = F_SQY;
            F_SQY: begin
                if (i_push_ready) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax     <= abs16(i_in.axis_x);
            r_ay     <= abs16(i_in.axis_y);
            r_active <= i_in.active;
        end
        if (r_state == F_SQX) begin
            r_sum <= product;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/mppw_queue.sv @@
// two-entry queue between front end and back end
`default_nettype none
module mppw_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire mppw_pkg::t_job_req i_push,
    output logic                 o_push_ready,
    input  wire                  i_pop,
    output mppw_pkg::t_job_req   o_head
);

    mppw_pkg::t_job r_mem [mppw_pkg::QUEUE_DEPTH];

    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_push_ready = (r_count != 2'(mppw_pkg::QUEUE_DEPTH));
    assign do_push      = i_push.valid && o_push_ready;
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.job   = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/mppw_back.sv @@
// back end: bit-serial square root, window extremes and result register
`default_nettype none
module mppw_back #(
    parameter int FRACTION_BITS = 8
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire [mppw_pkg::WL_W-1:0]    i_window_length,
    input  wire mppw_pkg::t_job_req     i_head,
    output logic                        o_pop,
    mppw_out_if.source                  o_out
);

    localparam int MAG_W  = mppw_pkg::P2P_W + FRACTION_BITS;
    localparam int RAD_W  = 2 * MAG_W;
    localparam int REM_W  = MAG_W + 2;
    localparam int STEP_W = $clog2(MAG_W);

    typedef enum logic [2:0] {
        B_IDLE   = 3'b001,
        B_ROOT   = 3'b010,
        B_UPDATE = 3'b100
    } t_bstate;

    t_bstate r_state, n_state;

    logic [RAD_W-1:0]          r_rad;
    logic [REM_W-1:0]          r_rem;
    logic [MAG_W-1:0]          r_root;
    logic [STEP_W-1:0]         r_step;
    logic [mppw_pkg::CNT_W-1:0] r_count;
    logic [MAG_W-1:0]          r_max, r_min;
    logic                      r_out_valid;
    logic [mppw_pkg::P2P_W-1:0] r_out_data;

    logic [REM_W-1:0]          rem_sh, trial;
    logic                      take;
    logic                      last_step;
    logic [MAG_W-1:0]          new_max, new_min, diff;
    logic [mppw_pkg::WL_W-1:0] wl_eff, count_next;
    logic                      window_done, out_free, update_go;

    assign rem_sh    = {r_rem[MAG_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign trial     = {r_root, 2'b01};
    assign take      = (rem_sh >= trial);
    assign last_step = (r_step == STEP_W'(MAG_W - 1));

    assign new_max = (r_root >= r_max) ? r_root : r_max;
    assign new_min = (r_root <= r_min) ? r_root : r_min;
    assign diff    = new_max - new_min;

    always_comb begin
        priority if (i_window_length == '0)
            wl_eff = mppw_pkg::WL_W'(1);
        else if (i_window_length > mppw_pkg::MAX_WINDOW)
            wl_eff = mppw_pkg::MAX_WINDOW;
        else
            wl_eff = i_window_length;
    end

    assign count_next  = {1'b0, r_count} + 1'b1;
    assign window_done = (count_next >= wl_eff);
    assign out_free    = !r_out_valid || o_out.ready;
    // a finishing window waits until the result register is free
    assign update_go   = (r_state == B_UPDATE) && (!window_done || out_free);

    assign o_pop = (r_state == B_IDLE) && i_head.valid;

    assign o_out.valid        = r_out_valid;
    assign o_out.peak_to_peak = r_out_data;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_head.valid && i_head.job.active) n_state = B_ROOT;
            end
            B_ROOT: begin
                if (last_step) n_state = B_UPDATE;
            end
            B_UPDATE: begin
                if (update_go) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_count     <= '0;
            r_max       <= '0;
            r_min       <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // a new result may replace one taken in the same cycle
            if (update_go && window_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && !i_head.job.active) begin
                r_count <= '0;
                r_max   <= '0;
                r_min   <= '1;
            end
            if (update_go) begin
                if (window_done) begin
                    r_count     <= '0;
                    r_max       <= '0;
                    r_min       <= '1;
                end else begin
                    r_count <= count_next[mppw_pkg::CNT_W-1:0];
                    r_max   <= new_max;
                    r_min   <= new_min;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.job.active) begin
            r_rad  <= {i_head.job.sum, {(RAD_W - mppw_pkg::SUM_W){1'b0}}};
            r_rem  <= '0;
            r_root <= '0;
            r_step <= '0;
        end else if (r_state == B_ROOT) begin
            // one result bit per cycle, two radicand bits consumed
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= take ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[MAG_W-2:0], take};
            r_step <= r_step + 1'b1;
        end
        if (update_go && window_done) begin
            r_out_data <= diff[MAG_W-1:FRACTION_BITS];
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/magnitude_peak_to_peak_window.sv @@
// top level of the magnitude peak-to-peak window detector
//
//  channel   dir  handshake         payload
//  i_in      in   valid / ready     active, axis_x, axis_y
//  o_out     out  valid / ready     peak_to_peak
//  i_cfg     in   i_cfg_we          i_cfg_data (window_length)
//
//  front end takes a request only when idle (one shared multiplier, x then y)
//  and holds the sum until the queue has room; back end pops only when idle and
//  finds one root bit per cycle; an inactive request only clears the window
//  a two-entry queue lets the front keep taking requests while the back works
//  a finished result waits in an output register; the back stalls only when a
//  second window ends before it is taken
//  synchronous active-low reset clears the window and sets window_length to 200
`default_nettype none
module magnitude_peak_to_peak_window #(
    parameter int FRACTION_BITS = 8
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    mppw_in_if.sink                     i_in,
    mppw_out_if.source                  o_out,
    input  wire                         i_cfg_we,
    input  wire [mppw_pkg::WL_W-1:0]    i_cfg_data
);

    logic [mppw_pkg::WL_W-1:0] r_window_length;
    mppw_pkg::t_job_req        push, head;
    logic                      push_ready, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= mppw_pkg::WL_RESET;
        end else if (i_cfg_we) begin
            r_window_length <= i_cfg_data;
        end
    end

    mppw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_push_ready (push_ready),
        .o_push       (push)
    );

    mppw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_head       (head)
    );

    mppw_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_window_length (r_window_length),
        .i_head          (head),
        .o_pop           (pop),
        .o_out           (o_out)
    );

endmodule
`default_nettype wire
